### rtl/two_class_priority_dispatcher_top_defines.svh
// Assertion macros for the dispatcher checker.
`ifndef TWO_CLASS_PRIORITY_DISPATCHER_TOP_DEFINES_SVH
`define TWO_CLASS_PRIORITY_DISPATCHER_TOP_DEFINES_SVH

// Check a property outside reset.
`define TCPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define TCPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tcpd_pkg.sv
`default_nettype none
package tcpd_pkg;

  localparam int URGENT_DEPTH_DEF = 16;
  localparam int NORMAL_DEPTH_DEF = 16;

  localparam int PRIO_W   = 4;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;

  localparam logic [PRIO_W-1:0] THRESH_RST = 4'd3;

  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  localparam logic OP_ENQ   = 1'b0;
  localparam logic OP_SERVE = 1'b1;

  typedef struct packed {
    logic                urg_ins;
    logic                urg_pop;
    logic                fifo_push;
    logic                fifo_pop;
    logic                load_out;
    logic                load_fifo;
    logic                sel_head;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic is_urgent;
    logic urg_full;
    logic urg_empty;
    logic fifo_full;
    logic fifo_empty;
  } stat_t;

endpackage
`default_nettype wire

### rtl/tcpd_if.sv
`default_nettype none
interface tcpd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [tcpd_pkg::ID_W-1:0]   item_id;
  logic [tcpd_pkg::PRIO_W-1:0] priority_req;

  modport source (output valid, output operation, output item_id, output priority_req,
                  input ready);
  modport sink (input valid, input operation, input item_id, input priority_req,
                output ready);
endinterface

interface tcpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcpd_pkg::STATUS_W-1:0] status;
  logic [tcpd_pkg::ID_W-1:0]     served_id;
  logic                          served_urgent;

  modport source (output valid, output status, output served_id, output served_urgent,
                  input ready);
  modport sink (input valid, input status, input served_id, input served_urgent,
                output ready);
endinterface

interface tcpd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tcpd_pkg::PRIO_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/two_class_priority_dispatcher_top.sv
// Two-class priority dispatcher.
// in_if carries one beat per request: operation 0 enqueues item_id with
// priority_req, operation 1 serves the next item. out_if returns one beat per
// request with status, served_id and served_urgent. cfg_if writes the urgent
// threshold; it is always ready. The user must write it only while the
// block is idle; the block itself does not enforce this. Enqueues at or above
// the threshold go to a sorted shift-register store, highest priority first,
// ties in arrival order; the rest go to a RAM FIFO. An enqueue, an urgent
// serve or an empty serve loads the output register directly; a serve taken
// from the FIFO passes the registered read of the FIFO RAM and the S_RD state
// before it loads the output register. Throughput: one request per cycle
// while the output drains; a FIFO serve holds in_if.ready low while in S_RD.
// The result sits in an output register; a new request is taken in the cycle
// that register is drained. While the receiver stalls, the result holds and
// in_if.ready stays low. Reset clears both stores to empty, sets the
// threshold to 3 and drops any pending result.
`default_nettype none
module two_class_priority_dispatcher_top #(
  parameter int URGENT_DEPTH = tcpd_pkg::URGENT_DEPTH_DEF,
  parameter int NORMAL_DEPTH = tcpd_pkg::NORMAL_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tcpd_in_if.sink     in_if,
  tcpd_out_if.source  out_if,
  tcpd_cfg_if.sink    cfg_if
);

  tcpd_pkg::cmd_t  cmd;
  tcpd_pkg::stat_t stat;

  assign cfg_if.ready = 1'b1;

  tcpd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_operation (in_if.operation),
    .in_ready     (in_if.ready),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  tcpd_dpath #(
    .URGENT_DEPTH (URGENT_DEPTH),
    .NORMAL_DEPTH (NORMAL_DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_if.valid && cfg_if.ready),
    .cfg_data          (cfg_if.data),
    .in_item_id        (in_if.item_id),
    .in_priority_req   (in_if.priority_req),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_if.status),
    .out_served_id     (out_if.served_id),
    .out_served_urgent (out_if.served_urgent)
  );

endmodule
`default_nettype wire

### rtl/tcpd_ram.sv
`default_nettype none
module tcpd_ram #(
  parameter int WIDTH = tcpd_pkg::ID_W,
  parameter int DEPTH = tcpd_pkg::NORMAL_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/tcpd_dpath.sv
`default_nettype none
module tcpd_dpath #(
  parameter int URGENT_DEPTH = tcpd_pkg::URGENT_DEPTH_DEF,
  parameter int NORMAL_DEPTH = tcpd_pkg::NORMAL_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [tcpd_pkg::PRIO_W-1:0]   cfg_data,
  input  wire logic [tcpd_pkg::ID_W-1:0]     in_item_id,
  input  wire logic [tcpd_pkg::PRIO_W-1:0]   in_priority_req,
  input  wire tcpd_pkg::cmd_t                cmd,
  output tcpd_pkg::stat_t                    stat,
  output logic      [tcpd_pkg::STATUS_W-1:0] out_status,
  output logic      [tcpd_pkg::ID_W-1:0]     out_served_id,
  output logic                               out_served_urgent
);

  localparam int UCW = $clog2(URGENT_DEPTH + 1);
  localparam int AW  = $clog2(NORMAL_DEPTH);
  localparam int NCW = $clog2(NORMAL_DEPTH + 1);

  localparam int PW = tcpd_pkg::PRIO_W;
  localparam int IW = tcpd_pkg::ID_W;

  logic [PW-1:0] thresh_r;

  logic [PW-1:0]  prio_r   [URGENT_DEPTH];
  logic [IW-1:0]  id_r     [URGENT_DEPTH];
  logic [PW-1:0]  prio_nxt [URGENT_DEPTH];
  logic [IW-1:0]  id_nxt   [URGENT_DEPTH];
  logic [PW-1:0]  prio_dn  [URGENT_DEPTH];
  logic [IW-1:0]  id_dn    [URGENT_DEPTH];
  logic [PW-1:0]  prio_up  [URGENT_DEPTH];
  logic [IW-1:0]  id_up    [URGENT_DEPTH];
  logic [URGENT_DEPTH-1:0] ge;
  logic [URGENT_DEPTH-1:0] ins_here;
  logic [UCW-1:0] ucnt_r;

  logic [AW-1:0]  head_r;
  logic [AW-1:0]  tail_r;
  logic [NCW-1:0] ncnt_r;
  logic [IW-1:0]  ram_rdata;

  logic [tcpd_pkg::STATUS_W-1:0] status_r;
  logic [IW-1:0]                 sid_r;
  logic                          surg_r;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(NORMAL_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= tcpd_pkg::THRESH_RST;
    end else if (cfg_we) begin
      thresh_r <= cfg_data;
    end
  end

  // sorted store cells, highest priority in cell 0
  for (genvar i = 0; i < URGENT_DEPTH; i++) begin : g_cell
    assign ge[i] = (UCW'(i) < ucnt_r) && (prio_r[i] >= in_priority_req);
    if (i == 0) begin : g_first
      assign ins_here[i] = !ge[i];
      assign prio_dn[i]  = prio_r[i];
      assign id_dn[i]    = id_r[i];
    end else begin : g_rest
      assign ins_here[i] = !ge[i] && ge[i-1];
      assign prio_dn[i]  = prio_r[i-1];
      assign id_dn[i]    = id_r[i-1];
    end
    if (i == URGENT_DEPTH - 1) begin : g_last
      assign prio_up[i] = prio_r[i];
      assign id_up[i]   = id_r[i];
    end else begin : g_inner
      assign prio_up[i] = prio_r[i+1];
      assign id_up[i]   = id_r[i+1];
    end

    always_comb begin
      prio_nxt[i] = prio_r[i];
      id_nxt[i]   = id_r[i];
      if (cmd.urg_ins && !ge[i]) begin
        if (ins_here[i]) begin
          prio_nxt[i] = in_priority_req;
          id_nxt[i]   = in_item_id;
        end else begin
          prio_nxt[i] = prio_dn[i];
          id_nxt[i]   = id_dn[i];
        end
      end else if (cmd.urg_pop) begin
        prio_nxt[i] = prio_up[i];
        id_nxt[i]   = id_up[i];
      end
    end

    always_ff @(posedge clk) begin
      prio_r[i] <= prio_nxt[i];
      id_r[i]   <= id_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ucnt_r <= '0;
    end else if (cmd.urg_ins) begin
      ucnt_r <= ucnt_r + UCW'(1);
    end else if (cmd.urg_pop) begin
      ucnt_r <= ucnt_r - UCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      ncnt_r <= '0;
    end else begin
      if (cmd.fifo_push) begin
        tail_r <= wrap_inc(tail_r);
      end
      if (cmd.fifo_pop) begin
        head_r <= wrap_inc(head_r);
      end
      if (cmd.fifo_push && !cmd.fifo_pop) begin
        ncnt_r <= ncnt_r + NCW'(1);
      end else if (cmd.fifo_pop && !cmd.fifo_push) begin
        ncnt_r <= ncnt_r - NCW'(1);
      end
    end
  end

  tcpd_ram #(
    .WIDTH (IW),
    .DEPTH (NORMAL_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (cmd.fifo_push),
    .waddr (tail_r),
    .wdata (in_item_id),
    .re    (cmd.fifo_pop),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r <= cmd.status;
      sid_r    <= cmd.sel_head ? id_r[0] : '0;
      surg_r   <= cmd.sel_head;
    end else if (cmd.load_fifo) begin
      status_r <= tcpd_pkg::ST_SERVED;
      sid_r    <= ram_rdata;
      surg_r   <= 1'b0;
    end
  end

  assign stat.is_urgent  = in_priority_req >= thresh_r;
  assign stat.urg_full   = ucnt_r == UCW'(URGENT_DEPTH);
  assign stat.urg_empty  = ucnt_r == '0;
  assign stat.fifo_full  = ncnt_r == NCW'(NORMAL_DEPTH);
  assign stat.fifo_empty = ncnt_r == '0;

  assign out_status        = status_r;
  assign out_served_id     = sid_r;
  assign out_served_urgent = surg_r;

endmodule
`default_nettype wire

### rtl/tcpd_ctrl.sv
`default_nettype none
module tcpd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_operation,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire tcpd_pkg::stat_t stat,
  output tcpd_pkg::cmd_t       cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic acc;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_operation)
            tcpd_pkg::OP_ENQ: begin
              cmd.load_out = 1'b1;
              if (stat.is_urgent) begin
                if (stat.urg_full) begin
                  cmd.status = tcpd_pkg::ST_FULL;
                end else begin
                  cmd.urg_ins = 1'b1;
                  cmd.status  = tcpd_pkg::ST_ENQUEUED;
                end
              end else begin
                if (stat.fifo_full) begin
                  cmd.status = tcpd_pkg::ST_FULL;
                end else begin
                  cmd.fifo_push = 1'b1;
                  cmd.status    = tcpd_pkg::ST_ENQUEUED;
                end
              end
            end
            tcpd_pkg::OP_SERVE: begin
              if (!stat.urg_empty) begin
                cmd.urg_pop  = 1'b1;
                cmd.load_out = 1'b1;
                cmd.sel_head = 1'b1;
                cmd.status   = tcpd_pkg::ST_SERVED;
              end else if (!stat.fifo_empty) begin
                cmd.fifo_pop = 1'b1;
                state_nxt    = S_RD;
              end else begin
                cmd.load_out = 1'b1;
                cmd.status   = tcpd_pkg::ST_EMPTY;
              end
            end
            default: begin
              cmd = '0;
            end
          endcase
        end
      end
      S_RD: begin
        cmd.load_fifo = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out || cmd.load_fifo) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### rtl/tcpd_chk.sv
`default_nettype none
`include "two_class_priority_dispatcher_top_defines.svh"
module tcpd_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [tcpd_pkg::STATUS_W-1:0] out_status,
  input wire logic [tcpd_pkg::ID_W-1:0]     out_served_id,
  input wire logic                          out_served_urgent
);

  `TCPD_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid, "output beat after reset")
  `TCPD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "output beat dropped")
  `TCPD_ASSERT(a_zero_unless_served, clk, rst_n, out_valid && (out_status != tcpd_pkg::ST_SERVED) |-> (out_served_id == '0) && !out_served_urgent, "nonzero id without serve")
  `TCPD_ASSERT(a_accept_progress, clk, rst_n, in_valid && in_ready |=> out_valid || !in_ready, "accepted beat gave no result")

endmodule

bind two_class_priority_dispatcher_top tcpd_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_status        (out_if.status),
  .out_served_id     (out_if.served_id),
  .out_served_urgent (out_if.served_urgent)
);
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic                        op;
    logic [tcpd_pkg::ID_W-1:0]   id;
    logic [tcpd_pkg::PRIO_W-1:0] prio;
  } request_t;

  typedef struct packed {
    logic [tcpd_pkg::STATUS_W-1:0] status;
    logic [tcpd_pkg::ID_W-1:0]     id;
    logic                          urgent;
  } outcome_t;

  logic clk;
  logic rst_n;

  tcpd_in_if  in_ch ();
  tcpd_out_if out_ch ();
  tcpd_cfg_if cfg_ch ();

  two_class_priority_dispatcher_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  request_t request_q[$];
  outcome_t outcome_due_q[$];
  int       errors;

  logic [tcpd_pkg::PRIO_W-1:0] thr_model;
  logic [tcpd_pkg::PRIO_W-1:0] urg_prio[tcpd_pkg::URGENT_DEPTH_DEF];
  logic [tcpd_pkg::ID_W-1:0]   urg_id[tcpd_pkg::URGENT_DEPTH_DEF];
  int                          urg_cnt;
  logic [tcpd_pkg::ID_W-1:0]   fifo_mem[tcpd_pkg::NORMAL_DEPTH_DEF];
  int                          fifo_rd;
  int                          fifo_wr;
  int                          fifo_cnt;

  int in_gap;
  bit in_burst;
  int out_stall;
  bit out_burst;

  task automatic report(string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  function automatic int wait_draw(bit burst);
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic outcome_t dispatch_step(request_t r);
    outcome_t o;
    int       pos;
    int       k;
    o = '0;
    o.status = tcpd_pkg::ST_ENQUEUED;
    pos = 0;
    if (r.op == tcpd_pkg::OP_ENQ) begin
      if (r.prio >= thr_model) begin
        if (urg_cnt >= tcpd_pkg::URGENT_DEPTH_DEF) begin
          o.status = tcpd_pkg::ST_FULL;
        end else begin
          while (pos < urg_cnt && urg_prio[pos] >= r.prio) pos++;
          for (k = urg_cnt; k > pos; k--) begin
            urg_prio[k] = urg_prio[k-1];
            urg_id[k]   = urg_id[k-1];
          end
          urg_prio[pos] = r.prio;
          urg_id[pos]   = r.id;
          urg_cnt++;
        end
      end else if (fifo_cnt >= tcpd_pkg::NORMAL_DEPTH_DEF) begin
        o.status = tcpd_pkg::ST_FULL;
      end else begin
        fifo_mem[fifo_wr] = r.id;
        fifo_wr = (fifo_wr + 1) % tcpd_pkg::NORMAL_DEPTH_DEF;
        fifo_cnt++;
      end
    end else if (urg_cnt > 0) begin
      o.status = tcpd_pkg::ST_SERVED;
      o.id     = urg_id[0];
      o.urgent = 1'b1;
      for (k = 1; k < urg_cnt; k++) begin
        urg_prio[k-1] = urg_prio[k];
        urg_id[k-1]   = urg_id[k];
      end
      urg_cnt--;
    end else if (fifo_cnt > 0) begin
      o.status = tcpd_pkg::ST_SERVED;
      o.id     = fifo_mem[fifo_rd];
      fifo_rd = (fifo_rd + 1) % tcpd_pkg::NORMAL_DEPTH_DEF;
      fifo_cnt--;
    end else begin
      o.status = tcpd_pkg::ST_EMPTY;
    end
    return o;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : request_driver
    request_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        nxt.op   = in_ch.operation;
        nxt.id   = in_ch.item_id;
        nxt.prio = in_ch.priority_req;
        outcome_due_q = {outcome_due_q, dispatch_step(nxt)};
      end
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        nxt = request_q[0];
        request_q.delete(0);
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= nxt.op;
        in_ch.item_id      <= nxt.id;
        in_ch.priority_req <= nxt.prio;
        if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
        in_gap <= wait_draw(in_burst);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    outcome_t exp;
    int       stall_next;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall <= 0;
    end else begin
      stall_next = out_stall;
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_due_q.size() == 0) begin
          report($sformatf("unexpected result beat status=%0d id=%h urgent=%0b",
                           out_ch.status, out_ch.served_id, out_ch.served_urgent));
        end else begin
          exp = outcome_due_q[0];
          outcome_due_q.delete(0);
          if (out_ch.status !== exp.status)
            report($sformatf("status got %0d want %0d", out_ch.status, exp.status));
          if (out_ch.served_id !== exp.id)
            report($sformatf("served_id got %h want %h", out_ch.served_id, exp.id));
          if (out_ch.served_urgent !== exp.urgent)
            report($sformatf("served_urgent got %0b want %0b",
                             out_ch.served_urgent, exp.urgent));
        end
        if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
        stall_next = wait_draw(out_burst);
      end
      if (stall_next > 0) begin
        out_ch.ready <= 1'b0;
        out_stall <= stall_next - 1;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall <= 0;
      end
    end
  end

  task automatic push_req(logic op, logic [tcpd_pkg::ID_W-1:0] id,
                          logic [tcpd_pkg::PRIO_W-1:0] prio);
    request_t r;
    r.op   = op;
    r.id   = id;
    r.prio = prio;
    request_q = {request_q, r};
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (request_q.size() != 0 || in_ch.valid || outcome_due_q.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [tcpd_pkg::PRIO_W-1:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    thr_model = v;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [tcpd_pkg::PRIO_W-1:0] thr;
    logic [tcpd_pkg::ID_W-1:0]   id;
    logic [tcpd_pkg::PRIO_W-1:0] prio;
    int                          enq_pct;
    int                          ph;
    int                          n;
    int                          drain_cycles;

    errors = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = tcpd_pkg::OP_ENQ;
    in_ch.item_id = '0;
    in_ch.priority_req = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    in_gap = 0;
    out_stall = 0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    thr_model = tcpd_pkg::THRESH_RST;
    urg_cnt = 0;
    fifo_rd = 0;
    fifo_wr = 0;
    fifo_cnt = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    push_req(tcpd_pkg::OP_SERVE, 16'h0000, 4'h0);
    push_req(tcpd_pkg::OP_ENQ, 16'hFFFF, 4'hF);
    push_req(tcpd_pkg::OP_ENQ, 16'h0000, 4'h0);
    push_req(tcpd_pkg::OP_ENQ, 16'h1234, 4'h3);
    push_req(tcpd_pkg::OP_ENQ, 16'h5678, 4'h2);
    push_req(tcpd_pkg::OP_ENQ, 16'h9ABC, 4'h3);
    push_req(tcpd_pkg::OP_ENQ, 16'hA5A5, 4'hF);
    push_req(tcpd_pkg::OP_ENQ, 16'h0001, 4'h4);
    repeat (7) push_req(tcpd_pkg::OP_SERVE, 16'hFFFF, 4'hF);
    push_req(tcpd_pkg::OP_SERVE, 16'h5A5A, 4'h7);
    push_req(tcpd_pkg::OP_SERVE, 16'h0000, 4'h0);
    push_req(tcpd_pkg::OP_ENQ, 16'h00FF, 4'h2);
    push_req(tcpd_pkg::OP_ENQ, 16'hFF00, 4'h9);
    push_req(tcpd_pkg::OP_SERVE, 16'h0000, 4'h0);
    push_req(tcpd_pkg::OP_SERVE, 16'h0000, 4'h0);
    push_req(tcpd_pkg::OP_SERVE, 16'h0000, 4'h0);

    for (ph = 0; ph < 12; ph++) begin
      wait_drained();
      case (ph)
        0:       thr = 4'd0;
        1:       thr = 4'd15;
        2:       thr = tcpd_pkg::THRESH_RST;
        default: thr = $urandom_range(0, 15);
      endcase
      write_threshold(thr);
      case ($urandom_range(0, 2))
        0:       enq_pct = 30;
        1:       enq_pct = 55;
        default: enq_pct = 80;
      endcase
      for (n = 0; n < 140; n++) begin
        case ($urandom_range(0, 9))
          0:       id = 16'h0000;
          1:       id = 16'hFFFF;
          default: id = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 3))
          0:       prio = thr;
          1:       prio = thr - 4'd1;
          default: prio = $urandom_range(0, 15);
        endcase
        if ($urandom_range(0, 99) < enq_pct) push_req(tcpd_pkg::OP_ENQ, id, prio);
        else push_req(tcpd_pkg::OP_SERVE, id, prio);
      end
    end

    @(negedge clk);
    drain_cycles = 0;
    while ((request_q.size() != 0 || in_ch.valid || outcome_due_q.size() != 0)
           && drain_cycles < 20000) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (5) @(posedge clk);
    if (outcome_due_q.size() != 0)
      report($sformatf("%0d results never arrived", outcome_due_q.size()));
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
